// ===== rtl/svfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svfd_pkg
// Shared types and constants of the slow variable frame decoder.
// ----------------------------------------------------------------------------
package svfd_pkg;

	localparam int FRAME_BYTES = 20;
	localparam int CNT_W       = 5;
	localparam int MAX_SLOTS   = 240;

	localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] SUM_BYTES = CNT_W'(18);
	localparam int               CTRL_POS  = 9;
	localparam int               WORD_A_POS = 10;
	localparam int               WORD_B_POS = 14;

	localparam logic [7:0]  START_MARK = 8'hFE;
	localparam logic [15:0] SUM_SEED   = 16'h5A5A;
	localparam logic [7:0]  SPP_RESET  = 8'd30;

	// configuration register indexes
	localparam logic REG_SPP = 1'b0;

	typedef enum logic [1:0] {
		KIND_CAL   = 2'd0,
		KIND_LABEL = 2'd1,
		KIND_DESC  = 2'd2
	} svfd_kind_t;

	typedef struct packed {
		logic        frame_ok;
		logic [7:0]  sample_slot;
		logic [63:0] channel_values;
		svfd_kind_t  record_kind;
		logic [6:0]  record_channel;
		logic        use_flag;
		logic [31:0] word_a;
		logic [31:0] word_b;
	} svfd_result_t;

endpackage
`default_nettype wire

// ===== rtl/svfd_collect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svfd_collect
// Frame assembly, running checksum, record decode and ring slot update.
// ----------------------------------------------------------------------------
module svfd_collect (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          byte_in,
	input  wire logic [7:0]          samples_per_page,
	output logic                     done,
	output svfd_pkg::svfd_result_t   result
);
	import svfd_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [15:0]      sum_q;
	logic [7:0]       slot_q;
	logic [7:0]       store_q [FRAME_BYTES];

	logic [15:0] sum_base;
	logic [15:0] sum_add;
	logic [15:0] sum_rot;
	logic        frame_ok;
	logic [7:0]  ctrl;
	logic [8:0]  limit;
	logic [8:0]  slot_next;
	logic [7:0]  slot_upd;

	assign sum_base = (count_q == '0) ? SUM_SEED : sum_q;
	assign sum_add  = sum_base + {8'd0, byte_in};
	assign sum_rot  = {sum_add[14:0], sum_add[15]};

	assign done     = step && (count_q == LAST_POS);
	assign frame_ok = ({byte_in, store_q[FRAME_BYTES-2]} == sum_q);
	assign ctrl     = store_q[CTRL_POS];

	assign limit     = (samples_per_page > 8'(MAX_SLOTS)) ? 9'(MAX_SLOTS)
		: {1'b0, samples_per_page};
	assign slot_next = {1'b0, slot_q} + 9'd1;
	assign slot_upd  = (slot_next >= limit) ? 8'd0 : slot_next[7:0];

	always_comb begin
		result                = '0;
		result.record_kind    = KIND_CAL;
		result.sample_slot    = slot_q;
		if (frame_ok) begin
			result.frame_ok = 1'b1;
			for (int k = 0; k < 8; k++) begin
				result.channel_values[8*k +: 8] = store_q[k+1];
			end
			for (int k = 0; k < 4; k++) begin
				result.word_a[8*k +: 8] = store_q[WORD_A_POS+k];
				result.word_b[8*k +: 8] = store_q[WORD_B_POS+k];
			end
			if (!ctrl[7]) begin
				result.record_kind    = KIND_DESC;
				result.record_channel = ctrl[6:0];
			end else if (!ctrl[6]) begin
				result.record_kind    = KIND_LABEL;
				result.record_channel = {4'd0, ctrl[2:0]};
			end else begin
				result.record_kind    = KIND_CAL;
				result.record_channel = {4'd0, ctrl[2:0]};
				result.use_flag       = ctrl[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= SUM_SEED;
			slot_q  <= '0;
		end else if (step) begin
			if (count_q == '0) begin
				// idle: only the start mark opens a frame
				if (byte_in == START_MARK) begin
					count_q <= CNT_W'(1);
					sum_q   <= sum_rot;
				end
			end else if (count_q == LAST_POS) begin
				count_q <= '0;
				sum_q   <= SUM_SEED;
				if (frame_ok) begin
					slot_q <= slot_upd;
				end
			end else begin
				count_q <= count_q + CNT_W'(1);
				if (count_q < SUM_BYTES) begin
					sum_q <= sum_rot;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && (count_q != '0 || byte_in == START_MARK)) begin
			store_q[count_q] <= byte_in;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_POS)
		else $error("frame position out of range");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < 8'(MAX_SLOTS))
		else $error("ring slot beyond slot limit");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.frame_ok |-> result.channel_values == '0
			&& result.word_a == '0 && result.word_b == '0 && !result.use_flag)
		else $error("dropped frame carries payload");

	a_slot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && frame_ok) |=> slot_q == $past(slot_q))
		else $error("slot moved without a good frame");

endmodule
`default_nettype wire

// ===== rtl/svfd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svfd_out_reg
// Result register holding one decoded frame until the receiver takes it.
// ----------------------------------------------------------------------------
module svfd_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire svfd_pkg::svfd_result_t load_data,
	output logic                     blocked,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output svfd_pkg::svfd_result_t   out_data
);
	import svfd_pkg::*;

	logic         valid_q;
	svfd_result_t data_q;

	assign blocked   = valid_q && out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!blocked) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !blocked) begin
			data_q <= load_data;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		blocked |=> valid_q && data_q == $past(data_q))
		else $error("pending request lost under stall");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && !blocked |=> valid_q)
		else $error("loaded result not presented");

	a_no_load_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		blocked |-> !load)
		else $error("result produced while output register is full");

endmodule
`default_nettype wire

// ===== rtl/slow_variable_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slow_variable_frame_decoder_unit
// Decodes 20-byte slow variable telemetry frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / rx_byte) takes one byte per
//   request. A frame opens on 0xFE while idle; other bytes are dropped then.
//   After the 20th byte of a frame one result request leaves on the output
//   channel (out_valid / out_stall) with the checksum flag, ring slot,
//   channel bytes and the decoded control record.
//   Throughput is one byte per cycle unless a result is stalled. A byte
//   passes an input register and the frame logic into the result register,
//   which loads a result as the final byte leaves the input register.
//   While the receiver stalls a pending result, the byte in the input
//   register waits and in_stall rises once that register is occupied;
//   nothing is dropped.
//   Reset clears the frame position, ring slot and pending requests, seeds
//   the checksum and sets samples_per_page to 30; the user must write it at
//   APB address 0 only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module slow_variable_frame_decoder_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// byte input
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             rx_byte,
	// result output
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        frame_ok,
	output logic [7:0]                  sample_slot,
	output logic [63:0]                 channel_values,
	output svfd_pkg::svfd_kind_t        record_kind,
	output logic [6:0]                  record_channel,
	output logic                        use_flag,
	output logic [31:0]                 word_a,
	output logic [31:0]                 word_b
);
	import svfd_pkg::*;

	logic [7:0]   spp_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         blocked;
	logic         step;
	logic         done;
	svfd_result_t result;
	svfd_result_t out_data;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q <= SPP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_SPP) begin
			spp_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SPP) begin
			prdata = {24'd0, spp_q};
		end
	end

	// input register
	assign in_stall = valid_s1 && blocked;
	assign step     = valid_s1 && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	svfd_collect u_collect (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.byte_in          (byte_s1),
		.samples_per_page (spp_q),
		.done             (done),
		.result           (result)
	);

	svfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (done),
		.load_data (result),
		.blocked   (blocked),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign frame_ok       = out_data.frame_ok;
	assign sample_slot    = out_data.sample_slot;
	assign channel_values = out_data.channel_values;
	assign record_kind    = out_data.record_kind;
	assign record_channel = out_data.record_channel;
	assign use_flag       = out_data.use_flag;
	assign word_a         = out_data.word_a;
	assign word_b         = out_data.word_b;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && byte_s1 == $past(byte_s1))
		else $error("held byte changed under stall");

	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(out_valid && out_stall))
		else $error("byte consumed while result blocked");

	a_spp_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == REG_SPP |=> spp_q == $past(pwdata[7:0]))
		else $error("register write not taken");

endmodule
`default_nettype wire

// ===== dv/tb_slow_variable_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slow_variable_frame_decoder_unit
// Self-checking bench for the slow variable frame decoder. A table of
// directed frames runs first, then phases of random frames, noise and
// corrupted checksums under several samples_per_page settings. Each result is
// checked field by field against a local decoder model or a table record.
// ----------------------------------------------------------------------------
module tb_slow_variable_frame_decoder_unit;
	import svfd_pkg::*;

	localparam logic [2:0] ADDR_SPP   = {REG_SPP, 2'b00};
	localparam logic [2:0] ADDR_SPARE = 3'd4;
	localparam int         DRAIN_CYCLES = 6;
	localparam int         PHASE_FRAMES = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_ok;
	logic [7:0]  sample_slot;
	logic [63:0] channel_values;
	svfd_kind_t  record_kind;
	logic [6:0]  record_channel;
	logic        use_flag;
	logic [31:0] word_a;
	logic [31:0] word_b;

	slow_variable_frame_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_ok       (frame_ok),
		.sample_slot    (sample_slot),
		.channel_values (channel_values),
		.record_kind    (record_kind),
		.record_channel (record_channel),
		.use_flag       (use_flag),
		.word_a         (word_a),
		.word_b         (word_b)
	);

	always #5 clk = ~clk;

	// decoder model state
	logic [7:0]       page_limit;
	logic [CNT_W-1:0] frame_pos;
	logic [15:0]      run_sum;
	logic [7:0]       held [FRAME_BYTES];
	logic [7:0]       ring_slot;

	svfd_result_t results_due [$];
	int           errors = 0;
	bit           calm = 1'b0;
	bit           want_override = 1'b0;
	svfd_result_t override_val;

	typedef struct {
		int unsigned  noise;
		logic [63:0]  chan;
		logic [7:0]   ctrl;
		logic [31:0]  wa;
		logic [31:0]  wb;
		logic [15:0]  flip;
		bit           typed;
		svfd_result_t want;
	} frame_row_t;

	localparam int DIR_ROWS = 12;
	frame_row_t dir_rows [DIR_ROWS] = '{
		'{0, 64'h0, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1,
			'{1'b1, 8'd0, 64'h0, KIND_DESC, 7'd0, 1'b0, 32'h0, 32'h0}},
		'{0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 1'b1,
			'{1'b1, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, KIND_CAL, 7'd7, 1'b1,
				32'hFFFF_FFFF, 32'hFFFF_FFFF}},
		// bad checksum, low byte off
		'{0, 64'h0123_4567_89AB_CDEF, 8'h7F, 32'hDEAD_BEEF, 32'h0102_0304, 16'h0001, 1'b1,
			'{1'b0, 8'd2, 64'h0, KIND_CAL, 7'd0, 1'b0, 32'h0, 32'h0}},
		// bad checksum, high byte off
		'{0, 64'h0123_4567_89AB_CDEF, 8'hC9, 32'hDEAD_BEEF, 32'h0102_0304, 16'h8000, 1'b1,
			'{1'b0, 8'd2, 64'h0, KIND_CAL, 7'd0, 1'b0, 32'h0, 32'h0}},
		// idle noise first, start marks inside the frame body
		'{3, 64'hFEFE_FEFE_FEFE_FEFE, 8'hB5, 32'h3F80_0000, 32'hBF80_0000, 16'h0, 1'b0, '0},
		'{0, 64'h8040_2010_0804_0201, 8'hBF, 32'h4142_4344, 32'h4546_4748, 16'h0, 1'b0, '0},
		'{0, 64'h7F3E_1D0C_FBEA_D9C8, 8'hC2, 32'h4049_0FDB, 32'hC049_0FDB, 16'h0, 1'b0, '0},
		'{0, 64'hA5A5_5A5A_A5A5_5A5A, 8'hCE, 32'h0000_0001, 32'h8000_0000, 16'h0, 1'b0, '0},
		'{0, 64'h1122_3344_5566_7788, 8'h7F, 32'h7FFF_FFFF, 32'h0000_FFFF, 16'h0, 1'b0, '0},
		'{1, 64'h00FF_00FF_00FF_00FF, 8'h80, 32'h2020_2020, 32'h7E7E_7E7E, 16'h0, 1'b0, '0},
		'{0, 64'hFF00_FF00_FF00_FF00, 8'h40, 32'hFFFF_0000, 32'h0000_FFFF, 16'h0, 1'b0, '0},
		'{0, 64'h5A5A_5A5A_5A5A_5A5A, 8'h08, 32'hCAFE_F00D, 32'hF00D_CAFE, 16'hFFFF, 1'b0, '0}
	};

	function automatic logic [15:0] sum_step(logic [15:0] s, logic [7:0] b);
		logic [15:0] t;
		t = s + {8'h00, b};
		return {t[14:0], t[15]};
	endfunction

	// returns 1 when the byte closes a frame, r then holds the decoded record
	function automatic bit decode_byte(logic [7:0] b, output svfd_result_t r);
		logic [7:0] ctrl;
		logic [8:0] lim;
		logic [8:0] nxt;
		r = '0;
		if (frame_pos == '0) begin
			if (b != START_MARK)
				return 1'b0;
			run_sum = SUM_SEED;
		end
		held[frame_pos] = b;
		if (frame_pos < SUM_BYTES)
			run_sum = sum_step(run_sum, b);
		frame_pos = frame_pos + 1'b1;
		if (int'(frame_pos) < FRAME_BYTES)
			return 1'b0;
		frame_pos = '0;
		r.sample_slot = ring_slot;
		if ({held[19], held[18]} == run_sum) begin
			r.frame_ok = 1'b1;
			for (int k = 1; k <= 8; k++)
				r.channel_values[8*(k-1) +: 8] = held[k];
			ctrl = held[CTRL_POS];
			if (!ctrl[7]) begin
				r.record_kind = KIND_DESC;
				r.record_channel = ctrl[6:0];
			end else if (!ctrl[6]) begin
				r.record_kind = KIND_LABEL;
				r.record_channel = {4'b0, ctrl[2:0]};
			end else begin
				r.record_kind = KIND_CAL;
				r.record_channel = {4'b0, ctrl[2:0]};
				r.use_flag = ctrl[3];
			end
			r.word_a = {held[WORD_A_POS+3], held[WORD_A_POS+2],
				held[WORD_A_POS+1], held[WORD_A_POS]};
			r.word_b = {held[WORD_B_POS+3], held[WORD_B_POS+2],
				held[WORD_B_POS+1], held[WORD_B_POS]};
			lim = (page_limit > MAX_SLOTS) ? 9'(MAX_SLOTS) : {1'b0, page_limit};
			nxt = {1'b0, ring_slot} + 9'd1;
			if (nxt >= lim)
				nxt = '0;
			ring_slot = nxt[7:0];
		end
		run_sum = SUM_SEED;
		return 1'b1;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want)
			report($sformatf("tb: mismatch on %s expected %h got %h", name, want, got));
	endtask

	// byte requests, called and left on a rising edge
	task automatic send_byte(logic [7:0] b);
		int unsigned  gap;
		logic         stalled;
		svfd_result_t r;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		if (decode_byte(b, r)) begin
			if (want_override) begin
				r = override_val;
				want_override = 1'b0;
			end
			results_due.push_back(r);
		end
	endtask

	task automatic send_noise(int unsigned n, bit no_mark);
		logic [7:0] b;
		repeat (n) begin
			do b = 8'($urandom); while (no_mark && b == START_MARK);
			send_byte(b);
		end
	endtask

	task automatic send_frame(logic [63:0] chan, logic [7:0] ctrl, logic [31:0] wa,
			logic [31:0] wb, logic [15:0] flip);
		logic [7:0]  fb [FRAME_BYTES];
		logic [15:0] s;
		fb[0] = START_MARK;
		for (int k = 0; k < 8; k++)
			fb[k+1] = chan[8*k +: 8];
		fb[CTRL_POS] = ctrl;
		for (int k = 0; k < 4; k++) begin
			fb[WORD_A_POS+k] = wa[8*k +: 8];
			fb[WORD_B_POS+k] = wb[8*k +: 8];
		end
		s = SUM_SEED;
		for (int k = 0; k < int'(SUM_BYTES); k++)
			s = sum_step(s, fb[k]);
		s = s ^ flip;
		fb[18] = s[7:0];
		fb[19] = s[15:8];
		for (int k = 0; k < FRAME_BYTES; k++)
			send_byte(fb[k]);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		logic rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_SPP)
			page_limit = data[7:0];
		// leave the bus idle before the next transfer
		@(posedge clk);
	endtask

	task automatic apb_check(logic [2:0] addr);
		logic        rdy;
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			got = prdata;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("samples_per_page", 64'(page_limit), 64'(got[7:0]));
		@(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver stalls: short runs mostly, now and then a long one
	int stall_run = 0;
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			int unsigned r;
			r = $urandom_range(0, 99);
			if (r < 55) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(0, 4);
			end else if (r < 93) begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(10, 40);
			end
		end
	end

	// results are taken at the next rising edge, so sample them at the falling one
	svfd_result_t mon_want;
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report("tb: unexpected result request");
			end else begin
				mon_want = results_due.pop_front();
				check_field("frame_ok", 64'(mon_want.frame_ok), 64'(frame_ok));
				check_field("sample_slot", 64'(mon_want.sample_slot), 64'(sample_slot));
				check_field("channel_values", mon_want.channel_values, channel_values);
				check_field("record_kind", 64'(mon_want.record_kind), 64'(record_kind));
				check_field("record_channel", 64'(mon_want.record_channel),
					64'(record_channel));
				check_field("use_flag", 64'(mon_want.use_flag), 64'(use_flag));
				check_field("word_a", 64'(mon_want.word_a), 64'(word_a));
				check_field("word_b", 64'(mon_want.word_b), 64'(word_b));
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("tb: failure");
		$finish;
	end

	logic [31:0] phase_vals [8];
	initial begin
		page_limit = SPP_RESET;
		frame_pos = '0;
		run_sum = SUM_SEED;
		ring_slot = '0;
		for (int k = 0; k < FRAME_BYTES; k++)
			held[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check(ADDR_SPP);

		foreach (dir_rows[i]) begin
			send_noise(dir_rows[i].noise, 1'b1);
			if (dir_rows[i].typed) begin
				want_override = 1'b1;
				override_val = dir_rows[i].want;
			end
			send_frame(dir_rows[i].chan, dir_rows[i].ctrl, dir_rows[i].wa,
				dir_rows[i].wb, dir_rows[i].flip);
		end

		// 240 lets the slot climb, 3 then lands below it and forces a wrap
		phase_vals = '{32'd240, 32'd3, 32'd1, 32'd0, 32'd255, 32'h1234_5602,
			32'($urandom_range(1, 240)), 32'hFFFF_FF1E};
		foreach (phase_vals[p]) begin
			wait_drain();
			apb_write(ADDR_SPP, phase_vals[p]);
			apb_check(ADDR_SPP);
			if (p == 2) begin
				// writes past the register list leave it alone
				apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
				apb_check(ADDR_SPP);
			end
			calm = ($urandom_range(0, 3) == 0);
			for (int f = 0; f < PHASE_FRAMES; ) begin
				int unsigned r;
				r = $urandom_range(0, 99);
				if (r < 12) begin
					send_noise($urandom_range(1, 6), 1'b0);
				end else begin
					send_frame({$urandom, $urandom}, 8'($urandom), $urandom, $urandom,
						(r < 26) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0);
					f++;
				end
			end
			// close any frame that noise opened
			while (frame_pos != '0)
				send_noise(1, 1'b0);
		end
		calm = 1'b0;

		wait_drain();
		if (errors == 0 && results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
